/* sv/timed_address_blocklist_defines.svh */
// ----------------------------------------------------------------------------
// timed_address_blocklist_defines.svh
// Assertion macros used by the top-level blocklist RTL.
// ----------------------------------------------------------------------------
`ifndef TIMED_ADDRESS_BLOCKLIST_DEFINES_SVH
`define TIMED_ADDRESS_BLOCKLIST_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define TAB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked also during reset.
`define TAB_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAB_ASSERT(name, prop, msg)
`define TAB_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

/* sv/tab_pkg.sv */
// ----------------------------------------------------------------------------
// tab_pkg
// Types and constants of the timed address blocklist.
// ----------------------------------------------------------------------------
package tab_pkg;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int BAN_W   = 24;

    localparam logic [BAN_W-1:0] BAN_SECONDS_RST = 24'd300;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              cmp_en;
        logic              upd_en;
        logic              insert;
        logic              any_hit;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] now;
        logic [BAN_W-1:0]  ban_seconds;
    } tab_ctl_t;

    // Per-cell status back to the controller
    typedef struct packed {
        logic match;
        logic live;
        logic take;
    } tab_stat_t;

endpackage

/* sv/tab_item_if.sv */
// ----------------------------------------------------------------------------
// tab_item_if
// Request channel: opcode, address and current time.
// ----------------------------------------------------------------------------
interface tab_item_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [tab_pkg::ADDR_W-1:0] address;
    logic [tab_pkg::TIME_W-1:0] now;

    modport source (output valid, output opcode, output address, output now, input ready);
    modport sink   (input valid, input opcode, input address, input now, output ready);
endinterface

/* sv/tab_result_if.sv */
// ----------------------------------------------------------------------------
// tab_result_if
// Result channel: banned and store_full flags.
// ----------------------------------------------------------------------------
interface tab_result_if;
    logic valid;
    logic ready;
    logic banned;
    logic store_full;

    modport source (output valid, output banned, output store_full, input ready);
    modport sink   (input valid, input banned, input store_full, output ready);
endinterface

/* sv/tab_cell.sv */
// ----------------------------------------------------------------------------
// tab_cell
// One blocklist entry: address, insert time stamp, compare and free-slot chain link.
// ----------------------------------------------------------------------------
module tab_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tab_pkg::tab_ctl_t  ctl,
    input  logic               free_in,
    output logic               free_out,
    output tab_pkg::tab_stat_t stat
);
    import tab_pkg::*;

    logic              valid_reg;
    logic              match_reg;
    logic              live_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] time_reg;

    logic              match_next;
    logic              live_next;
    logic [TIME_W:0]   expiry;
    logic              take;

    assign match_next = valid_reg && (addr_reg == ctl.address);
    // 33-bit sum, no wrap
    assign expiry    = {1'b0, time_reg} + {{(TIME_W + 1 - BAN_W){1'b0}}, ctl.ban_seconds};
    assign live_next = expiry >= {1'b0, ctl.now};

    // lowest empty cell takes a new address
    assign take     = ctl.upd_en && ctl.insert && !ctl.any_hit && !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.cmp_en)
            begin
                match_reg <= match_next;
                live_reg  <= live_next;
            end
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (ctl.upd_en && !ctl.insert && match_reg && !live_reg)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            addr_reg <= ctl.address;
        end
        if (take || (ctl.upd_en && ctl.insert && match_reg))
        begin
            time_reg <= ctl.now;
        end
    end

    assign stat.match = match_reg;
    assign stat.live  = live_reg;
    assign stat.take  = take;

endmodule

/* sv/timed_address_blocklist.sv */
// ----------------------------------------------------------------------------
// timed_address_blocklist
// Fully associative store of banned IPv4 addresses with ban timeout.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  item      in   valid/ready    opcode, address, now
//  result    out  valid/ready    banned, store_full
//  cfg       in   cfg_we         cfg_data (ban_seconds)
//
//  Each item runs a compare phase against every cell, then an update phase
//  that updates the matching or lowest free cell and registers the result.
//  A new item is taken in the update phase of the last one, while the
//  result register is drained.
//  Reset empties every cell at once; no clearing pass.
//  A stalled result holds the update cycle until the result register frees.
// ----------------------------------------------------------------------------
`include "timed_address_blocklist_defines.svh"

module timed_address_blocklist #(
    parameter int ENTRIES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tab_item_if.sink                   item,
    tab_result_if.source               result,
    input  logic                       cfg_we,
    input  logic [tab_pkg::BAN_W-1:0]  cfg_data
);
    import tab_pkg::*;

    localparam logic PH_CMP = 1'b0;
    localparam logic PH_UPD = 1'b1;

    logic              busy_reg;
    logic              phase_reg;
    logic              op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic [BAN_W-1:0]  ban_seconds_reg;
    logic              out_valid_reg;
    logic              banned_reg;
    logic              full_reg;

    logic               accept;
    logic               out_free;
    logic               upd_done;
    logic               any_hit;
    tab_ctl_t           ctl;
    tab_stat_t          stat [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] live_vec;
    logic [ENTRIES-1:0] take_vec;
    logic [ENTRIES:0]   free_chain;

    assign out_free = !out_valid_reg || result.ready;
    assign upd_done = busy_reg && (phase_reg == PH_UPD) && out_free;
    assign item.ready = !busy_reg || upd_done;
    assign accept   = item.valid && item.ready;
    assign any_hit  = |match_vec;

    assign ctl.cmp_en      = busy_reg && (phase_reg == PH_CMP);
    assign ctl.upd_en      = upd_done;
    assign ctl.insert      = (op_reg == OP_INSERT);
    assign ctl.any_hit     = any_hit;
    assign ctl.address     = addr_reg;
    assign ctl.now         = now_reg;
    assign ctl.ban_seconds = ban_seconds_reg;

    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        tab_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .free_in  (free_chain[i]),
            .free_out (free_chain[i+1]),
            .stat     (stat[i])
        );
        assign match_vec[i] = stat[i].match;
        assign live_vec[i]  = stat[i].live;
        assign take_vec[i]  = stat[i].take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            phase_reg       <= PH_CMP;
            ban_seconds_reg <= BAN_SECONDS_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ban_seconds_reg <= cfg_data;
            end
            if (accept)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_CMP;
            end
            else if (upd_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (ctl.cmp_en)
            begin
                phase_reg <= PH_UPD;
            end
            if (upd_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item.opcode;
            addr_reg <= item.address;
            now_reg  <= item.now;
        end
        if (upd_done)
        begin
            banned_reg <= (op_reg == OP_QUERY) && |(match_vec & live_vec);
            // full chain end: no empty cell anywhere
            full_reg   <= (op_reg == OP_INSERT) && !any_hit && !free_chain[ENTRIES];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.banned     = banned_reg;
    assign result.store_full = full_reg;

    `TAB_ASSERT(a_single_match, ctl.upd_en |-> $onehot0(match_vec), "address in two cells")
    `TAB_ASSERT_ALWAYS(a_single_take, $onehot0(take_vec), "insert claimed two cells")
    `TAB_ASSERT(a_result_follows_update, upd_done |=> result.valid, "no result after update")
    `TAB_ASSERT(a_take_only_on_miss, (|take_vec) |-> (ctl.insert && !any_hit), "claim on hit")

endmodule

/* tb/blocklist_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blocklist_checker
// Watches the request, result and config ports of the blocklist, keeps its
// own copy of the address cells and ban time, and compares each result
// transfer field by field against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module blocklist_checker #(
    parameter int ENTRIES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  logic                        item_opcode,
    input  logic [tab_pkg::ADDR_W-1:0]  item_address,
    input  logic [tab_pkg::TIME_W-1:0]  item_now,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic                        result_banned,
    input  logic                        result_store_full,
    input  logic                        cfg_we,
    input  logic [tab_pkg::BAN_W-1:0]   cfg_data,
    output int                          errors,
    output int                          pending,
    output int                          banned_seen,
    output int                          full_seen
);
    import tab_pkg::*;

    typedef struct packed {
        logic banned;
        logic store_full;
    } verdict_t;

    logic [BAN_W-1:0]  ban_seconds;
    logic              cell_used  [ENTRIES];
    logic [ADDR_W-1:0] cell_addr  [ENTRIES];
    logic [TIME_W-1:0] cell_stamp [ENTRIES];
    verdict_t          verdict_q  [$];
    verdict_t          want;
    int                r;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    // Updates the cell copy for one request and returns the flags it must produce.
    function automatic verdict_t apply_request(input logic op,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [TIME_W-1:0] t);
        verdict_t          v;
        int                hit;
        int                slot;
        int                i;
        logic [TIME_W:0]   deadline;
        v    = '0;
        hit  = -1;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (cell_used[i] && cell_addr[i] == addr && hit < 0)
                hit = i;
            if (!cell_used[i] && slot < 0)
                slot = i;
        end
        if (op == OP_INSERT)
        begin
            if (hit >= 0)
                cell_stamp[hit] = t;
            else if (slot >= 0)
            begin
                cell_used[slot]  = 1'b1;
                cell_addr[slot]  = addr;
                cell_stamp[slot] = t;
            end
            else
                v.store_full = 1'b1;
        end
        else if (hit >= 0)
        begin
            // 33-bit sum, no wrap
            deadline = {1'b0, cell_stamp[hit]} + (TIME_W+1)'(ban_seconds);
            if (deadline >= {1'b0, t})
                v.banned = 1'b1;
            else
                cell_used[hit] = 1'b0;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ban_seconds = BAN_SECONDS_RST;
            for (r = 0; r < ENTRIES; r++)
                cell_used[r] = 1'b0;
            verdict_q.delete();
            errors      = 0;
            pending     = 0;
            banned_seen = 0;
            full_seen   = 0;
        end
        else
        begin
            if (cfg_we)
                ban_seconds = cfg_data;
            if (result_valid && result_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result transfer with no request outstanding");
                else
                begin
                    want = verdict_q.pop_front();
                    if (result_banned !== want.banned)
                        report_mismatch($sformatf("banned got %b want %b",
                                                  result_banned, want.banned));
                    if (result_store_full !== want.store_full)
                        report_mismatch($sformatf("store_full got %b want %b",
                                                  result_store_full, want.store_full));
                    banned_seen += int'(want.banned);
                    full_seen   += int'(want.store_full);
                end
            end
            if (item_valid && item_ready)
                verdict_q.push_back(apply_request(item_opcode, item_address, item_now));
            pending = verdict_q.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the blocklist with directed and random insert/query streams across
// several ban_seconds settings, with random idling on both channels, a long
// result hold-off and drain pauses; the checker judges every result.
// ----------------------------------------------------------------------------
module tb;
    import tab_pkg::*;

    localparam int N_CELLS     = 64;
    localparam int POOL_N      = 96;
    localparam int HOLD_CYCLES = 400;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [BAN_W-1:0] cfg_data;

    logic              no_idle;
    logic              hold_req;
    logic [TIME_W-1:0] clock_s;
    logic [ADDR_W-1:0] pool [POOL_N];
    int                n_sent;
    int                n_settings;
    int                errors;
    int                pending;
    int                banned_seen;
    int                full_seen;

    tab_item_if   item_ch ();
    tab_result_if result_ch ();

    timed_address_blocklist #(.ENTRIES(N_CELLS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    blocklist_checker #(.ENTRIES(N_CELLS)) chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_ch.valid),
        .item_ready        (item_ch.ready),
        .item_opcode       (item_ch.opcode),
        .item_address      (item_ch.address),
        .item_now          (item_ch.now),
        .result_valid      (result_ch.valid),
        .result_ready      (result_ch.ready),
        .result_banned     (result_ch.banned),
        .result_store_full (result_ch.store_full),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .errors            (errors),
        .pending           (pending),
        .banned_seen       (banned_seen),
        .full_seen         (full_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            result_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 7);
        end
    end

    // Returns at the falling edge after the request transfer, valid still high.
    task automatic offer_request(input logic op, input logic [ADDR_W-1:0] addr,
                                 input logic [TIME_W-1:0] t);
        while (!no_idle && $urandom_range(99) < 7)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= op;
        item_ch.address <= addr;
        item_ch.now     <= t;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_ban_seconds(input logic [BAN_W-1:0] secs);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= secs;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        n_settings++;
    endtask

    // Mostly pool addresses and a forward-moving clock; some stray addresses
    // and times that jump backwards or anywhere.
    task automatic run_phase(input int n_items, input int unsigned span);
        int                k;
        int unsigned       pick;
        logic              op;
        logic [ADDR_W-1:0] a;
        logic [TIME_W-1:0] t;
        for (k = 0; k < n_items; k++)
        begin
            op   = 1'($urandom_range(1));
            pick = $urandom_range(99);
            a    = (pick < 85) ? pool[$urandom_range(POOL_N-1)] : ADDR_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 90)
            begin
                clock_s = clock_s + $urandom_range(span);
                t       = clock_s;
            end
            else if (pick < 95)
                t = clock_s - $urandom_range(span * 4 + 4);
            else
                t = $urandom;
            offer_request(op, a, t);
            if ($urandom_range(199) == 0)
                drain_results();
        end
    endtask

    // Fill every cell, let them expire unqueried, then free them by queries.
    task automatic fill_store();
        logic [ADDR_W-1:0] fresh [N_CELLS];
        logic [TIME_W-1:0] t0;
        int                i;
        set_ban_seconds(5);
        t0 = clock_s;
        for (i = 0; i < N_CELLS; i++)
        begin
            fresh[i] = $urandom;
            offer_request(OP_INSERT, fresh[i], t0);
        end
        for (i = 0; i < 3; i++)
            offer_request(OP_INSERT, $urandom, t0 + 100);
        offer_request(OP_INSERT, fresh[10], t0 + 100);
        offer_request(OP_QUERY, fresh[3], t0 + 200);
        offer_request(OP_QUERY, fresh[20], t0 + 200);
        for (i = 0; i < 3; i++)
            offer_request(OP_INSERT, $urandom, t0 + 200);
        offer_request(OP_QUERY, fresh[10], t0 + 105);
        for (i = 0; i < N_CELLS; i++)
            offer_request(OP_QUERY, fresh[i], t0 + 300);
        clock_s = t0 + 300;
    endtask

    initial
    begin : stimulus
        logic [BAN_W-1:0] r_ban;
        int               i;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = OP_QUERY;
        item_ch.address = '0;
        item_ch.now     = '0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        n_sent          = 0;
        n_settings      = 0;
        clock_s         = $urandom;
        for (i = 0; i < POOL_N; i++)
            pool[i] = $urandom;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: boundaries at reset ban time of 300
        offer_request(OP_QUERY,  32'h0000_0000, 32'd0);
        offer_request(OP_INSERT, 32'h0000_0000, 32'd0);
        offer_request(OP_QUERY,  32'h0000_0000, 32'd300);
        offer_request(OP_QUERY,  32'h0000_0000, 32'd301);
        offer_request(OP_QUERY,  32'h0000_0000, 32'd0);
        // deadline past 2^32 must not wrap
        offer_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FF00);
        offer_request(OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // refresh with time going backwards
        offer_request(OP_INSERT, 32'hFFFF_FFFF, 32'd100);
        offer_request(OP_QUERY,  32'hFFFF_FFFF, 32'd50);
        offer_request(OP_QUERY,  32'hFFFF_FFFF, 32'd401);
        // refresh of an expired entry not yet queried
        offer_request(OP_INSERT, 32'hC0A8_0101, 32'd10);
        offer_request(OP_INSERT, 32'hC0A8_0101, 32'd600);
        offer_request(OP_QUERY,  32'hC0A8_0101, 32'd900);
        offer_request(OP_QUERY,  32'hC0A8_0101, 32'd901);
        set_ban_seconds('0);
        offer_request(OP_INSERT, 32'h0A00_0001, 32'd1000);
        offer_request(OP_QUERY,  32'h0A00_0001, 32'd1000);
        offer_request(OP_QUERY,  32'h0A00_0001, 32'd1001);
        set_ban_seconds('1);
        offer_request(OP_INSERT, 32'h5555_AAAA, 32'd0);
        offer_request(OP_QUERY,  32'h5555_AAAA, 32'd16_777_215);
        offer_request(OP_QUERY,  32'h5555_AAAA, 32'd16_777_216);

        fill_store();

        set_ban_seconds('0);
        run_phase(220, 2);
        set_ban_seconds('1);
        hold_req = 1'b1;
        run_phase(220, 1_600_000);
        set_ban_seconds(7);
        run_phase(220, 3);
        set_ban_seconds(60);
        no_idle = 1'b1;
        run_phase(220, 8);
        drain_results();
        no_idle = 1'b0;
        r_ban = BAN_W'($urandom_range(1, 5000));
        set_ban_seconds(r_ban);
        run_phase(220, r_ban / 8 + 2);
        set_ban_seconds(1);
        run_phase(220, 1);
        set_ban_seconds(BAN_SECONDS_RST);
        run_phase(220, 40);

        item_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        $display("Covered %0d request transfers over %0d ban_seconds settings.",
                 n_sent, n_settings);
        $display("Results: %0d banned, %0d store-full, %0d mismatches.",
                 banned_seen, full_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
